[rtl/aprt_pkg.sv]
// Package for the affine point/rectangle transform.
// Holds shared widths, operation and register codes, the coefficient set
// and the saturation function. Depends on nothing.
package aprt_pkg;

   localparam int COEF_W          = 32;
   localparam int OUT_W           = 32;
   localparam int OP_W            = 2;
   localparam int CORNERS         = 4;
   localparam int DEF_COORD_WIDTH = 16;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int NUM_REGS        = 6;
   localparam int CSR_ADDR_W      = $clog2(NUM_REGS * 4);
   localparam int REG_IDX_W       = CSR_ADDR_W - 2;
   localparam int CSR_DATA_W      = 32;
   localparam int SAT_IN_W        = 64;

   typedef enum logic [OP_W-1:0] {
      OP_POINT = 2'd0,
      OP_SIZE  = 2'd1,
      OP_RECT  = 2'd2
   } op_type;

   localparam logic [REG_IDX_W-1:0] REG_COEF_A  = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_COEF_B  = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_COEF_C  = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_COEF_D  = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = REG_IDX_W'(4);
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = REG_IDX_W'(5);

   typedef struct packed {
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
      logic [COEF_W-1:0] d;
      logic [COEF_W-1:0] tx;
      logic [COEF_W-1:0] ty;
   } coef_set_type;

   localparam logic signed [SAT_IN_W-1:0] SAT_MAX =
      {{(SAT_IN_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [SAT_IN_W-1:0] SAT_MIN =
      {{(SAT_IN_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[OUT_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/aprt_csr.sv]
// Register file for the affine transform: matrix and translation registers.
// Uses aprt_pkg for register codes and the coefficient set.
module aprt_csr
   import aprt_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output coef_set_type          coefs
);

   localparam logic [COEF_W-1:0] UNITY = COEF_W'(1) << FRAC_BITS;

   logic [COEF_W-1:0]    coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic [COEF_W-1:0]    shift_x_ff, shift_y_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff  <= UNITY;
         coef_b_ff  <= '0;
         coef_c_ff  <= '0;
         coef_d_ff  <= UNITY;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_COEF_A:  coef_a_ff  <= pwdata;
            REG_COEF_B:  coef_b_ff  <= pwdata;
            REG_COEF_C:  coef_c_ff  <= pwdata;
            REG_COEF_D:  coef_d_ff  <= pwdata;
            REG_SHIFT_X: shift_x_ff <= pwdata;
            REG_SHIFT_Y: shift_y_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_COEF_A:  prdata = coef_a_ff;
         REG_COEF_B:  prdata = coef_b_ff;
         REG_COEF_C:  prdata = coef_c_ff;
         REG_COEF_D:  prdata = coef_d_ff;
         REG_SHIFT_X: prdata = shift_x_ff;
         REG_SHIFT_Y: prdata = shift_y_ff;
         default:     prdata = '0;
      endcase
   end

   assign coefs.a  = coef_a_ff;
   assign coefs.b  = coef_b_ff;
   assign coefs.c  = coef_c_ff;
   assign coefs.d  = coef_d_ff;
   assign coefs.tx = shift_x_ff;
   assign coefs.ty = shift_y_ff;

endmodule

[rtl/aprt_mul.sv]
// Pipeline stage 1: the eight coefficient-by-coordinate products.
// Uses aprt_pkg for widths and the coefficient set.
module aprt_mul
   import aprt_pkg::*;
#(
   parameter int  COORD_WIDTH = DEF_COORD_WIDTH,
   localparam int PROD_W      = COEF_W + COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [OP_W-1:0]               in_op,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic signed [COORD_WIDTH-1:0] in_w,
   input  logic signed [COORD_WIDTH-1:0] in_h,
   input  coef_set_type                  coefs,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [OP_W-1:0]               out_op,
   output logic signed [PROD_W-1:0]      out_ax,
   output logic signed [PROD_W-1:0]      out_cy,
   output logic signed [PROD_W-1:0]      out_aw,
   output logic signed [PROD_W-1:0]      out_ch,
   output logic signed [PROD_W-1:0]      out_bx,
   output logic signed [PROD_W-1:0]      out_dy,
   output logic signed [PROD_W-1:0]      out_bw,
   output logic signed [PROD_W-1:0]      out_dh
);

   logic signed [PROD_W-1:0] ca, cb, cc, cd, ex, ey, ew, eh;
   logic                     s1_v_ff;
   logic [OP_W-1:0]          op_ff;
   logic signed [PROD_W-1:0] ax_ff, cy_ff, aw_ff, ch_ff, bx_ff, dy_ff, bw_ff, dh_ff;

   assign ca = PROD_W'($signed(coefs.a));
   assign cb = PROD_W'($signed(coefs.b));
   assign cc = PROD_W'($signed(coefs.c));
   assign cd = PROD_W'($signed(coefs.d));
   assign ex = PROD_W'(in_x);
   assign ey = PROD_W'(in_y);
   assign ew = PROD_W'(in_w);
   assign eh = PROD_W'(in_h);

   assign in_ready = !s1_v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (in_ready) begin
         s1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         op_ff <= in_op;
         ax_ff <= ca * ex;
         cy_ff <= cc * ey;
         aw_ff <= ca * ew;
         ch_ff <= cc * eh;
         bx_ff <= cb * ex;
         dy_ff <= cd * ey;
         bw_ff <= cb * ew;
         dh_ff <= cd * eh;
      end
   end

   assign out_valid = s1_v_ff;
   assign out_op    = op_ff;
   assign out_ax    = ax_ff;
   assign out_cy    = cy_ff;
   assign out_aw    = aw_ff;
   assign out_ch    = ch_ff;
   assign out_bx    = bx_ff;
   assign out_dy    = dy_ff;
   assign out_bw    = bw_ff;
   assign out_dh    = dh_ff;

endmodule

[rtl/aprt_corner.sv]
// Pipeline stages 2 and 3: base sums, then the four exact corner sums.
// Uses aprt_pkg for widths and the coefficient set.
module aprt_corner
   import aprt_pkg::*;
#(
   parameter int  COORD_WIDTH = DEF_COORD_WIDTH,
   localparam int PROD_W      = COEF_W + COORD_WIDTH,
   localparam int ACC_W       = COEF_W + COORD_WIDTH + 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [OP_W-1:0]          in_op,
   input  logic signed [PROD_W-1:0] in_ax,
   input  logic signed [PROD_W-1:0] in_cy,
   input  logic signed [PROD_W-1:0] in_aw,
   input  logic signed [PROD_W-1:0] in_ch,
   input  logic signed [PROD_W-1:0] in_bx,
   input  logic signed [PROD_W-1:0] in_dy,
   input  logic signed [PROD_W-1:0] in_bw,
   input  logic signed [PROD_W-1:0] in_dh,
   input  coef_set_type             coefs,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [OP_W-1:0]          out_op,
   output logic signed [ACC_W-1:0]  out_cx [CORNERS],
   output logic signed [ACC_W-1:0]  out_cy [CORNERS],
   output logic signed [ACC_W-1:0]  out_szx,
   output logic signed [ACC_W-1:0]  out_szy
);

   logic signed [ACC_W-1:0] tx_ext, ty_ext;
   logic                    s2_v_ff, s3_v_ff, s2_ready, s3_ready;
   logic [OP_W-1:0]         s2_op_ff, s3_op_ff;
   logic signed [ACC_W-1:0] basex_ff, basey_ff, szx_ff, szy_ff;
   logic signed [ACC_W-1:0] ewx_ff, ehx_ff, ewy_ff, ehy_ff;
   logic signed [ACC_W-1:0] cx_ff [CORNERS];
   logic signed [ACC_W-1:0] cy_ff [CORNERS];
   logic signed [ACC_W-1:0] s3_szx_ff, s3_szy_ff;

   assign tx_ext = ACC_W'($signed(coefs.tx));
   assign ty_ext = ACC_W'($signed(coefs.ty));

   assign s3_ready = !s3_v_ff || out_ready;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign in_ready = s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_v_ff <= in_valid;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s2_ready) begin
         s2_op_ff <= in_op;
         basex_ff <= ACC_W'(in_ax) + ACC_W'(in_cy) + tx_ext;
         basey_ff <= ACC_W'(in_bx) + ACC_W'(in_dy) + ty_ext;
         szx_ff   <= ACC_W'(in_aw) + ACC_W'(in_ch);
         szy_ff   <= ACC_W'(in_bw) + ACC_W'(in_dh);
         ewx_ff   <= ACC_W'(in_aw);
         ehx_ff   <= ACC_W'(in_ch);
         ewy_ff   <= ACC_W'(in_bw);
         ehy_ff   <= ACC_W'(in_dh);
      end
   end

   // corner order: origin, +w, +h, +w+h
   always_ff @(posedge clock) begin
      if (s2_v_ff && s3_ready) begin
         s3_op_ff  <= s2_op_ff;
         cx_ff[0]  <= basex_ff;
         cx_ff[1]  <= basex_ff + ewx_ff;
         cx_ff[2]  <= basex_ff + ehx_ff;
         cx_ff[3]  <= basex_ff + szx_ff;
         cy_ff[0]  <= basey_ff;
         cy_ff[1]  <= basey_ff + ewy_ff;
         cy_ff[2]  <= basey_ff + ehy_ff;
         cy_ff[3]  <= basey_ff + szy_ff;
         s3_szx_ff <= szx_ff;
         s3_szy_ff <= szy_ff;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_op    = s3_op_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;
   assign out_szx   = s3_szx_ff;
   assign out_szy   = s3_szy_ff;

endmodule

[rtl/aprt_bbox.sv]
// Pipeline stages 4 to 6: min/max tree, floor, extent, saturation and the
// output register. Uses aprt_pkg for widths, operation codes and sat_out.
module aprt_bbox
   import aprt_pkg::*;
#(
   parameter int  COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int  FRAC_BITS   = DEF_FRAC_BITS,
   localparam int ACC_W       = COEF_W + COORD_WIDTH + 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [OP_W-1:0]          in_op,
   input  logic signed [ACC_W-1:0]  in_cx [CORNERS],
   input  logic signed [ACC_W-1:0]  in_cy [CORNERS],
   input  logic signed [ACC_W-1:0]  in_szx,
   input  logic signed [ACC_W-1:0]  in_szy,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [OUT_W-1:0]  out_x,
   output logic signed [OUT_W-1:0]  out_y,
   output logic signed [OUT_W-1:0]  out_width,
   output logic signed [OUT_W-1:0]  out_height
);

   localparam int FL_W  = ACC_W - FRAC_BITS;
   localparam int EXT_W = FL_W + 1;

   logic                    s4_v_ff, s5_v_ff, s6_v_ff;
   logic                    s4_ready, s5_ready, s6_ready;
   logic [OP_W-1:0]         s4_op_ff, s5_op_ff, s6_op_ff;
   logic signed [ACC_W-1:0] lox01_ff, hix01_ff, lox23_ff, hix23_ff;
   logic signed [ACC_W-1:0] loy01_ff, hiy01_ff, loy23_ff, hiy23_ff;
   logic signed [ACC_W-1:0] ptx_ff, pty_ff, s4_szx_ff, s4_szy_ff;
   logic signed [ACC_W-1:0] lox_in, hix_in, loy_in, hiy_in;
   logic signed [FL_W-1:0]  fl_lox_ff, fl_hix_ff, fl_loy_ff, fl_hiy_ff;
   logic signed [FL_W-1:0]  fl_ptx_ff, fl_pty_ff, fl_szx_ff, fl_szy_ff;
   logic signed [EXT_W-1:0] extx, exty;
   logic signed [OUT_W-1:0] x_in, y_in, width_in, height_in;
   logic signed [OUT_W-1:0] x_ff, y_ff, width_ff, height_ff;

   assign s6_ready = !s6_v_ff || out_ready;
   assign s5_ready = !s5_v_ff || s6_ready;
   assign s4_ready = !s4_v_ff || s5_ready;
   assign in_ready = s4_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (s4_ready) begin
            s4_v_ff <= in_valid;
         end
         if (s5_ready) begin
            s5_v_ff <= s4_v_ff;
         end
         if (s6_ready) begin
            s6_v_ff <= s5_v_ff;
         end
      end
   end

   // stage 4: pairwise min/max
   always_ff @(posedge clock) begin
      if (in_valid && s4_ready) begin
         s4_op_ff  <= in_op;
         lox01_ff  <= (in_cx[1] < in_cx[0]) ? in_cx[1] : in_cx[0];
         hix01_ff  <= (in_cx[1] > in_cx[0]) ? in_cx[1] : in_cx[0];
         lox23_ff  <= (in_cx[3] < in_cx[2]) ? in_cx[3] : in_cx[2];
         hix23_ff  <= (in_cx[3] > in_cx[2]) ? in_cx[3] : in_cx[2];
         loy01_ff  <= (in_cy[1] < in_cy[0]) ? in_cy[1] : in_cy[0];
         hiy01_ff  <= (in_cy[1] > in_cy[0]) ? in_cy[1] : in_cy[0];
         loy23_ff  <= (in_cy[3] < in_cy[2]) ? in_cy[3] : in_cy[2];
         hiy23_ff  <= (in_cy[3] > in_cy[2]) ? in_cy[3] : in_cy[2];
         ptx_ff    <= in_cx[0];
         pty_ff    <= in_cy[0];
         s4_szx_ff <= in_szx;
         s4_szy_ff <= in_szy;
      end
   end

   // stage 5: final min/max, then floor by arithmetic shift
   assign lox_in = (lox23_ff < lox01_ff) ? lox23_ff : lox01_ff;
   assign hix_in = (hix23_ff > hix01_ff) ? hix23_ff : hix01_ff;
   assign loy_in = (loy23_ff < loy01_ff) ? loy23_ff : loy01_ff;
   assign hiy_in = (hiy23_ff > hiy01_ff) ? hiy23_ff : hiy01_ff;

   always_ff @(posedge clock) begin
      if (s4_v_ff && s5_ready) begin
         s5_op_ff  <= s4_op_ff;
         fl_lox_ff <= FL_W'(lox_in >>> FRAC_BITS);
         fl_hix_ff <= FL_W'(hix_in >>> FRAC_BITS);
         fl_loy_ff <= FL_W'(loy_in >>> FRAC_BITS);
         fl_hiy_ff <= FL_W'(hiy_in >>> FRAC_BITS);
         fl_ptx_ff <= FL_W'(ptx_ff >>> FRAC_BITS);
         fl_pty_ff <= FL_W'(pty_ff >>> FRAC_BITS);
         fl_szx_ff <= FL_W'(s4_szx_ff >>> FRAC_BITS);
         fl_szy_ff <= FL_W'(s4_szy_ff >>> FRAC_BITS);
      end
   end

   // stage 6: extent, saturation, selection
   assign extx = EXT_W'(fl_hix_ff) - EXT_W'(fl_lox_ff);
   assign exty = EXT_W'(fl_hiy_ff) - EXT_W'(fl_loy_ff);

   always_comb begin
      x_in      = '0;
      y_in      = '0;
      width_in  = '0;
      height_in = '0;
      case (s5_op_ff)
         OP_POINT: begin
            x_in = sat_out(SAT_IN_W'(fl_ptx_ff));
            y_in = sat_out(SAT_IN_W'(fl_pty_ff));
         end
         OP_SIZE: begin
            width_in  = sat_out(SAT_IN_W'(fl_szx_ff));
            height_in = sat_out(SAT_IN_W'(fl_szy_ff));
         end
         OP_RECT: begin
            x_in      = sat_out(SAT_IN_W'(fl_lox_ff));
            y_in      = sat_out(SAT_IN_W'(fl_loy_ff));
            width_in  = sat_out(SAT_IN_W'(extx));
            height_in = sat_out(SAT_IN_W'(exty));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s5_v_ff && s6_ready) begin
         s6_op_ff  <= s5_op_ff;
         x_ff      <= x_in;
         y_ff      <= y_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign out_valid  = s6_v_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_width  = width_ff;
   assign out_height = height_ff;

`ifndef SYNTHESIS
   a_lo_le_hi: assert property (@(posedge clock) disable iff (reset)
      s5_v_ff |-> (fl_lox_ff <= fl_hix_ff) && (fl_loy_ff <= fl_hiy_ff))
      else $error("bounding box min above max");

   a_rect_extent: assert property (@(posedge clock) disable iff (reset)
      s6_v_ff && (s6_op_ff == OP_RECT) |-> !width_ff[OUT_W-1] && !height_ff[OUT_W-1])
      else $error("negative rectangle extent");

   a_point_no_size: assert property (@(posedge clock) disable iff (reset)
      s6_v_ff && (s6_op_ff == OP_POINT) |-> (width_ff == '0) && (height_ff == '0))
      else $error("point beat carries a size");

   a_size_no_origin: assert property (@(posedge clock) disable iff (reset)
      s6_v_ff && (s6_op_ff == OP_SIZE) |-> (x_ff == '0) && (y_ff == '0))
      else $error("size beat carries an origin");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s6_v_ff && !out_ready |=> s6_v_ff && $stable(x_ff) && $stable(width_ff))
      else $error("output stage changed while stalled");
`endif

endmodule

[rtl/affine_point_rect_transform.sv]
// Affine point/size/rectangle transform: applies the Q.FRAC_BITS matrix held in the
// csr_ registers to one req_ beat per clock and returns one rsp_ beat for each, in
// order, through a six-stage pipeline (products, base sums, corner sums, pairwise
// min/max, final min/max with floor, extent/saturation); a new beat may enter every
// cycle, and back-pressure on rsp_ready stalls stage by stage while bubbles ahead
// of the stall are filled. Registers: coef_a 0x00, coef_b 0x04, coef_c 0x08,
// coef_d 0x0C, shift_x 0x10, shift_y 0x14; write them only when idle.
// Depends on aprt_pkg, aprt_csr, aprt_mul, aprt_corner and aprt_bbox.
module affine_point_rect_transform
   import aprt_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [OP_W-1:0]               req_operation,
   input  logic signed [COORD_WIDTH-1:0] req_in_x,
   input  logic signed [COORD_WIDTH-1:0] req_in_y,
   input  logic signed [COORD_WIDTH-1:0] req_in_width,
   input  logic signed [COORD_WIDTH-1:0] req_in_height,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [OUT_W-1:0]       rsp_out_x,
   output logic signed [OUT_W-1:0]       rsp_out_y,
   output logic signed [OUT_W-1:0]       rsp_out_width,
   output logic signed [OUT_W-1:0]       rsp_out_height
);

   localparam int PROD_W = COEF_W + COORD_WIDTH;
   localparam int ACC_W  = COEF_W + COORD_WIDTH + 3;

   coef_set_type             coefs;
   logic                     m_valid, m_ready, c_valid, c_ready;
   logic [OP_W-1:0]          m_op, c_op;
   logic signed [PROD_W-1:0] m_ax, m_cy, m_aw, m_ch, m_bx, m_dy, m_bw, m_dh;
   logic signed [ACC_W-1:0]  c_cx [CORNERS];
   logic signed [ACC_W-1:0]  c_cy [CORNERS];
   logic signed [ACC_W-1:0]  c_szx, c_szy;

   aprt_csr #(
      .FRAC_BITS(FRAC_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .coefs   (coefs)
   );

   aprt_mul #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_op     (req_operation),
      .in_x      (req_in_x),
      .in_y      (req_in_y),
      .in_w      (req_in_width),
      .in_h      (req_in_height),
      .coefs     (coefs),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .out_op    (m_op),
      .out_ax    (m_ax),
      .out_cy    (m_cy),
      .out_aw    (m_aw),
      .out_ch    (m_ch),
      .out_bx    (m_bx),
      .out_dy    (m_dy),
      .out_bw    (m_bw),
      .out_dh    (m_dh)
   );

   aprt_corner #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .in_op     (m_op),
      .in_ax     (m_ax),
      .in_cy     (m_cy),
      .in_aw     (m_aw),
      .in_ch     (m_ch),
      .in_bx     (m_bx),
      .in_dy     (m_dy),
      .in_bw     (m_bw),
      .in_dh     (m_dh),
      .coefs     (coefs),
      .out_valid (c_valid),
      .out_ready (c_ready),
      .out_op    (c_op),
      .out_cx    (c_cx),
      .out_cy    (c_cy),
      .out_szx   (c_szx),
      .out_szy   (c_szy)
   );

   aprt_bbox #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_bbox (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c_valid),
      .in_ready   (c_ready),
      .in_op      (c_op),
      .in_cx      (c_cx),
      .in_cy      (c_cy),
      .in_szx     (c_szx),
      .in_szy     (c_szy),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .out_width  (rsp_out_width),
      .out_height (rsp_out_height)
   );

endmodule
